### rtl/deferred_free_index_allocator_top_assert.svh
// Assertion macros for the allocator
`ifndef DEFERRED_FREE_INDEX_ALLOCATOR_TOP_ASSERT_SVH
`define DEFERRED_FREE_INDEX_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define DFIA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DFIA_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFIA_ASSERT(label, clk, rst, prop, msg)
`define DFIA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/dfia_pkg.sv
package dfia_pkg;
   localparam int MAX_SLOTS   = 1024;
   localparam int FRAME_COUNT = 3;
   localparam int IDX_W       = $clog2(MAX_SLOTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int FRM_W       = 2;
   localparam int LIST_AW     = FRM_W + IDX_W;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_PROCESS = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [2:0] REG_CAPACITY = 3'd0;
   localparam logic [2:0] REG_VISIBLE  = 3'd1;
   localparam logic [2:0] REG_STRIDE   = 3'd2;
   localparam logic [2:0] REG_CPU_BASE = 3'd3;
   localparam logic [2:0] REG_GPU_BASE = 3'd4;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [10:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [63:0] quotient;
      logic        rem_zero;
   } div_rsp_type;
endpackage

### rtl/dfia_divider.sv
module dfia_divider import dfia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   // radix-2 restoring divide, one quotient bit per cycle
   logic [63:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [10:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [11:0] trial;
   logic [12:0] diff;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[10:0], quo_ff[63]};
      diff = {1'b0, trial} - {2'b0, dvs_ff};
      if (req.start) begin
         quo_in = req.dividend; rem_in = '0; dvs_in = req.divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[12]) begin
            rem_in = diff[11:0]; quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial; quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.rem_zero = (rem_ff == '0);
endmodule

### rtl/deferred_free_index_allocator_top.sv
// channel | direction | tdata fields (low first)                              | tuser
// req_    | in        | command, frame_number, handle_valid, slot_cpu_address, | -
//         |           | slot_number_claimed                                   |
// rsp_    | out       | status, slot_number, out_cpu_address, out_gpu_address, | -
//         |           | freed_count                                           |
// From acceptance to a valid result: allocate reads the free stack and forms
// the addresses; free runs the radix-2 divider and writes the list entry;
// process does one memory read and one stack write per list entry. Full,
// rejected and empty-list cases skip to the output. A new item can be taken as
// soon as the result is valid. After reset and every capacity write a clearing
// pass rewrites the free stack to identity, with req_tready low.
// One item at a time; a held result blocks the next one only in the final step.
`include "deferred_free_index_allocator_top_assert.svh"
module deferred_free_index_allocator_top import dfia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command, frame_number, handle_valid, slot_cpu_address, slot_number_claimed
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, slot_number, out_cpu_address, out_gpu_address, freed_count
   output logic [151:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_AMUL = 4'd3,
      S_DSTART = 4'd4, S_DWAIT = 4'd5, S_FCHK = 4'd6, S_PRD = 4'd7, S_PWR = 4'd8,
      S_OUT = 4'd9;

   logic [10:0] cap_ff; logic vis_ff; logic [10:0] stride_ff;
   logic [63:0] cbase_ff, gbase_ff;
   logic [3:0]  st_ff, st_in;
   logic [10:0] alloc_ff, alloc_in;
   logic [10:0] len_ff [FRAME_COUNT];
   logic [IDX_W:0] init_ff, init_in;
   logic [1:0]  cmd_ff, frm_ff; logic hv_ff; logic [63:0] addr_ff; logic [9:0] clm_ff;
   logic [10:0] k_ff, k_in, n_ff, n_in;
   logic [9:0]  idx_ff, idx_in;
   logic [1:0]  ost_ff, ost_in; logic [9:0] oslot_ff, oslot_in;
   logic [63:0] ocpu_ff, ocpu_in, ogpu_ff, ogpu_in, off_ff, off_in;
   logic [10:0] ofr_ff, ofr_in;
   logic        ov_ff, ov_in;
   logic [150:0] rsp_data_ff, rsp_data_in;
   logic        len_clr, len_inc;

   logic [IDX_W-1:0] stk_mem [MAX_SLOTS];
   logic [IDX_W-1:0] lst_mem [FRAME_COUNT*MAX_SLOTS];
   logic [IDX_W-1:0] stk_q, lst_q;
   logic stk_we; logic [IDX_W-1:0] stk_wa, stk_wd, stk_ra;
   logic lst_we; logic [LIST_AW-1:0] lst_wa, lst_ra;

   div_req_type dreq; div_rsp_type drsp;
   dfia_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [10:0] ecap;
   assign ecap = (cap_ff > 11'(MAX_SLOTS)) ? 11'(MAX_SLOTS) : cap_ff;
   logic cap_wr;
   assign cap_wr = csr_we && (csr_index == REG_CAPACITY);
   logic acc;
   assign req_tready = (st_ff == S_IDLE);
   assign acc = req_tvalid && req_tready;
   logic frm_ok;
   assign frm_ok = (frm_ff < 2'(FRAME_COUNT));
   logic [10:0] cur_len;
   assign cur_len = frm_ok ? len_ff[frm_ff] : '0;

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_q <= stk_mem[stk_ra];
      if (lst_we) lst_mem[lst_wa] <= idx_ff;
      lst_q <= lst_mem[lst_ra];
   end

   always_comb begin
      st_in = st_ff; alloc_in = alloc_ff; init_in = init_ff;
      k_in = k_ff; n_in = n_ff; idx_in = idx_ff; off_in = off_ff;
      ost_in = ost_ff; oslot_in = oslot_ff; ocpu_in = ocpu_ff; ogpu_in = ogpu_ff;
      ofr_in = ofr_ff; ov_in = ov_ff; rsp_data_in = rsp_data_ff;
      stk_we = 1'b0; stk_wa = init_ff[IDX_W-1:0]; stk_wd = init_ff[IDX_W-1:0];
      stk_ra = alloc_ff[IDX_W-1:0];
      lst_we = 1'b0; lst_wa = {frm_ff, cur_len[IDX_W-1:0]};
      lst_ra = {frm_ff, k_ff[IDX_W-1:0]};
      dreq.start = 1'b0; dreq.dividend = addr_ff - cbase_ff; dreq.divisor = stride_ff;
      len_clr = 1'b0; len_inc = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_INIT: begin
            stk_we = 1'b1;
            init_in = init_ff + 1'b1;
            if (init_ff == (IDX_W+1)'(MAX_SLOTS - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               ost_in = ST_IGNORED; oslot_in = '0; ocpu_in = '0; ogpu_in = '0;
               ofr_in = '0; k_in = '0;
               case (req_tdata[1:0])
                  CMD_ALLOC: st_in = S_ARD;
                  CMD_FREE: st_in = S_DSTART;
                  CMD_PROCESS: st_in = S_PRD;
                  default: st_in = S_OUT;
               endcase
            end
         end
         S_ARD: begin
            if (alloc_ff >= ecap) begin
               ost_in = ST_FULL; st_in = S_OUT;
            end else st_in = S_AMUL;
         end
         S_AMUL: begin
            off_in = 64'(21'(stk_q) * 21'(stride_ff));
            oslot_in = stk_q;
            alloc_in = alloc_ff + 11'd1;
            ost_in = ST_OK;
            st_in = S_FCHK;
         end
         S_DSTART: begin
            if (!hv_ff || !frm_ok) st_in = S_OUT;
            else if (addr_ff < cbase_ff || stride_ff == '0) begin
               ost_in = ST_BAD; st_in = S_OUT;
            end else begin
               dreq.start = 1'b1; st_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (drsp.done) begin
               if (!drsp.rem_zero || drsp.quotient >= 64'(ecap) ||
                   drsp.quotient[9:0] != clm_ff) ost_in = ST_BAD;
               else if (cur_len >= 11'(MAX_SLOTS)) ost_in = ST_IGNORED;
               else begin
                  ost_in = ST_OK; idx_in = drsp.quotient[9:0];
                  oslot_in = drsp.quotient[9:0]; st_in = S_FCHK;
               end
               if (st_in != S_FCHK) st_in = S_OUT;
            end
         end
         S_FCHK: begin
            // alloc: finish addresses; free: write list entry
            if (cmd_ff == CMD_ALLOC) begin
               ocpu_in = cbase_ff + off_ff;
               ogpu_in = vis_ff ? gbase_ff + off_ff : '0;
            end else begin
               lst_we = 1'b1; len_inc = 1'b1;
            end
            st_in = S_OUT;
         end
         S_PRD: begin
            if (!frm_ok) st_in = S_OUT;
            else begin
               n_in = cur_len;
               ost_in = ST_OK;
               if (cur_len == '0 || alloc_ff == '0) begin
                  len_clr = 1'b1; st_in = S_OUT;
               end else begin
                  k_in = k_ff + 11'd1; st_in = S_PWR;
               end
            end
         end
         S_PWR: begin
            stk_we = 1'b1;
            stk_wa = 10'(alloc_ff - 11'd1);
            stk_wd = lst_q;
            alloc_in = alloc_ff - 11'd1;
            ofr_in = ofr_ff + 11'd1;
            if (k_ff >= n_ff || alloc_ff == 11'd1) begin
               len_clr = 1'b1; st_in = S_OUT;
            end else begin
               st_in = S_PRD;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; st_in = S_IDLE;
               rsp_data_in = {ofr_ff, ogpu_ff, ocpu_ff, oslot_ff, ost_ff};
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (cap_wr) begin
         st_in = S_INIT; init_in = '0; alloc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in; idx_ff <= idx_in; n_ff <= n_in;
      ost_ff <= ost_in; oslot_ff <= oslot_in; ocpu_ff <= ocpu_in; ogpu_ff <= ogpu_in;
      ofr_ff <= ofr_in; k_ff <= k_in; rsp_data_ff <= rsp_data_in;
      if (acc) begin
         cmd_ff <= req_tdata[1:0]; frm_ff <= req_tdata[3:2]; hv_ff <= req_tdata[4];
         addr_ff <= req_tdata[68:5]; clm_ff <= req_tdata[78:69];
      end
      if (reset) begin
         st_ff <= S_INIT; init_ff <= '0; alloc_ff <= '0; ov_ff <= 1'b0;
         cap_ff <= 11'd1024; vis_ff <= 1'b0; stride_ff <= 11'd32;
         cbase_ff <= '0; gbase_ff <= '0;
         for (int i = 0; i < FRAME_COUNT; i++) len_ff[i] <= '0;
      end else begin
         st_ff <= st_in; init_ff <= init_in; alloc_ff <= alloc_in; ov_ff <= ov_in;
         if (cap_wr) begin
            for (int i = 0; i < FRAME_COUNT; i++) len_ff[i] <= '0;
         end else if (len_clr) len_ff[frm_ff] <= '0;
         else if (len_inc) len_ff[frm_ff] <= len_ff[frm_ff] + 11'd1;
         if (csr_we) begin
            case (csr_index)
               REG_CAPACITY: cap_ff <= csr_wdata[10:0];
               REG_VISIBLE: vis_ff <= csr_wdata[0];
               REG_STRIDE: stride_ff <= csr_wdata[10:0];
               REG_CPU_BASE: cbase_ff <= csr_wdata;
               REG_GPU_BASE: gbase_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {1'b0, rsp_data_ff};

   `DFIA_ASSERT(a_busy_not_ready, clock, reset, (st_ff != S_IDLE) |-> !req_tready,
      "ready outside idle")
   `DFIA_ASSERT(a_alloc_cap, clock, reset, (st_ff != S_INIT) |-> (alloc_ff <= 11'(MAX_SLOTS)),
      "allocated count overflow")
   `DFIA_ASSERT(a_div_once, clock, reset, dreq.start |-> !drsp.busy,
      "divider restarted while busy")
   `DFIA_ASSERT(a_out_hold, clock, reset, (ov_ff && !rsp_tready) |=> ov_ff,
      "result dropped")
   `DFIA_ASSERT(a_out_stable, clock, reset, (ov_ff && !rsp_tready) |=> $stable(rsp_tdata),
      "result changed while waiting")
endmodule
